// ===== sv/whp_pkg.sv =====
// Shared types, status codes and tag table for the WAV header parser.
package whp_pkg;

  // Result status codes.
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusBadHeader = 2'd1;
  localparam logic [1:0] StatusTruncated = 2'd2;

  // One input beat: a file byte and the end-of-file mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  status;
    logic        big_endian;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic        signed_samples;
  } out_beat_t;

  // Result handed from the parser core to the output buffer.
  typedef struct packed {
    logic      push;
    out_beat_t beat;
  } result_push_t;

  // Expected bytes of the first 16 header bytes; entries 4 to 7 hold the
  // unchecked RIFF size and entry 3 is checked separately (F or X).
  localparam logic [7:0] TagBytes [16] = '{
    8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h57, 8'h41, 8'h56, 8'h45, 8'h66, 8'h6d, 8'h74, 8'h20
  };

  localparam logic [7:0] ByteUpperF = 8'h46;
  localparam logic [7:0] ByteUpperX = 8'h58;

endpackage

// ===== sv/whp_core.sv =====
// Byte-wise header parser state machine; produces at most one result per beat.
module whp_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  whp_pkg::in_beat_t     beat,
  output whp_pkg::result_push_t result
);

  // Parser phases.
  localparam logic [2:0] PhHeader = 3'd0;
  localparam logic [2:0] PhExtra  = 3'd1;
  localparam logic [2:0] PhSkip   = 3'd2;
  localparam logic [2:0] PhData   = 3'd3;
  localparam logic [2:0] PhDone   = 3'd4;

  localparam logic [5:0] HeaderLast = 6'd35;
  localparam logic [5:0] DataLast   = 6'd7;
  localparam logic [7:0] FmtBaseSize = 8'd24;

  logic [2:0]  phase, phase_next;
  logic [5:0]  byte_count, byte_count_next;
  logic        hdr_ok, hdr_ok_next;
  logic        is_rifx, is_rifx_next;
  logic        fmt_big, fmt_big_next;
  logic [15:0] channel_field, channel_field_next;
  logic [31:0] rate_field, rate_field_next;
  logic [15:0] sample_bits_field, sample_bits_field_next;
  logic [15:0] skip_remaining, skip_remaining_next;

  logic [7:0] b;
  assign b = beat.data_byte;

  // Next-state and result logic for one accepted beat.
  always_comb begin
    phase_next             = phase;
    byte_count_next        = byte_count;
    hdr_ok_next            = hdr_ok;
    is_rifx_next           = is_rifx;
    fmt_big_next           = fmt_big;
    channel_field_next     = channel_field;
    rate_field_next        = rate_field;
    sample_bits_field_next = sample_bits_field;
    skip_remaining_next    = skip_remaining;
    result                 = '0;

    if (accept) begin
      case (phase)
        PhHeader: begin
          // Check tags and capture fields by byte position.
          case (byte_count) inside
            6'd0, 6'd1, 6'd2, [6'd8:6'd15]: begin
              if (b != whp_pkg::TagBytes[byte_count[3:0]]) hdr_ok_next = 1'b0;
            end
            6'd3: begin
              if (b == whp_pkg::ByteUpperX) is_rifx_next = 1'b1;
              else if (b != whp_pkg::ByteUpperF) hdr_ok_next = 1'b0;
            end
            6'd16: begin
              if (b > FmtBaseSize) fmt_big_next = 1'b1;
            end
            [6'd17:6'd19]: begin
              if (b != 8'd0) fmt_big_next = 1'b1;
            end
            6'd20: begin
              if (b > 8'd1) hdr_ok_next = 1'b0;
            end
            6'd21: begin
              if (b != 8'd0) hdr_ok_next = 1'b0;
            end
            6'd22: channel_field_next[7:0]  = b;
            6'd23: channel_field_next[15:8] = b;
            6'd24: rate_field_next[7:0]     = b;
            6'd25: rate_field_next[15:8]    = b;
            6'd26: rate_field_next[23:16]   = b;
            6'd27: rate_field_next[31:24]   = b;
            6'd34: sample_bits_field_next[7:0]  = b;
            6'd35: sample_bits_field_next[15:8] = b;
            default: ;
          endcase

          if (byte_count == HeaderLast) begin
            byte_count_next = '0;
            if (!hdr_ok_next) begin
              result.push        = 1'b1;
              result.beat.status = whp_pkg::StatusBadHeader;
              phase_next         = PhDone;
            end else if (fmt_big_next) begin
              phase_next = PhExtra;
            end else begin
              phase_next = PhData;
            end
          end else begin
            byte_count_next = byte_count + 6'd1;
          end
        end

        PhExtra: begin
          // Little-endian count of extra fmt bytes to skip.
          if (byte_count == 6'd0) begin
            skip_remaining_next = {8'd0, b};
            byte_count_next     = 6'd1;
          end else begin
            skip_remaining_next = {b, skip_remaining[7:0]};
            byte_count_next     = '0;
            phase_next = ({b, skip_remaining[7:0]} != 16'd0) ? PhSkip : PhData;
          end
        end

        PhSkip: begin
          skip_remaining_next = skip_remaining - 16'd1;
          if (skip_remaining == 16'd1) phase_next = PhData;
        end

        PhData: begin
          // Data chunk id and size pass unchecked; the last one emits the result.
          if (byte_count == DataLast) begin
            byte_count_next                 = '0;
            result.push                     = 1'b1;
            result.beat.status              = whp_pkg::StatusOk;
            result.beat.big_endian          = is_rifx;
            result.beat.channels            = channel_field;
            result.beat.sample_rate         = rate_field;
            result.beat.bits_per_sample     = sample_bits_field;
            result.beat.signed_samples      = (sample_bits_field != 16'd8);
            phase_next                      = PhDone;
          end else begin
            byte_count_next = byte_count + 6'd1;
          end
        end

        default: ;
      endcase

      // End of file: report truncation if no result yet, then rearm.
      if (beat.end_of_stream) begin
        if (!result.push && phase_next != PhDone) begin
          result.push        = 1'b1;
          result.beat.status = whp_pkg::StatusTruncated;
        end
        phase_next             = PhHeader;
        byte_count_next        = '0;
        hdr_ok_next            = 1'b1;
        is_rifx_next           = 1'b0;
        fmt_big_next           = 1'b0;
        channel_field_next     = '0;
        rate_field_next        = '0;
        sample_bits_field_next = '0;
        skip_remaining_next    = '0;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PhHeader;
      byte_count        <= '0;
      hdr_ok            <= 1'b1;
      is_rifx           <= 1'b0;
      fmt_big           <= 1'b0;
      channel_field     <= '0;
      rate_field        <= '0;
      sample_bits_field <= '0;
      skip_remaining    <= '0;
    end else begin
      phase             <= phase_next;
      byte_count        <= byte_count_next;
      hdr_ok            <= hdr_ok_next;
      is_rifx           <= is_rifx_next;
      fmt_big           <= fmt_big_next;
      channel_field     <= channel_field_next;
      rate_field        <= rate_field_next;
      sample_bits_field <= sample_bits_field_next;
      skip_remaining    <= skip_remaining_next;
    end
  end

endmodule

// ===== sv/whp_out_buf.sv =====
// Result register with a skid entry that separates output stall from input stall.
module whp_out_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  whp_pkg::result_push_t result,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output whp_pkg::out_beat_t    out_data
);

  logic               main_valid;
  logic               skid_valid;
  whp_pkg::out_beat_t main_beat;
  whp_pkg::out_beat_t skid_beat;
  logic               pop;

  assign pop       = main_valid && !out_stall;
  assign out_valid = main_valid;
  assign out_data  = main_beat;
  assign full      = skid_valid;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= result.push;
      end
    end else if (result.push) begin
      if (!main_valid) main_valid <= 1'b1;
      else skid_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) main_beat <= skid_beat;
      else if (result.push) main_beat <= result.beat;
    end else if (result.push) begin
      if (!main_valid) main_beat <= result.beat;
      else skid_beat <= result.beat;
    end
  end

endmodule

// ===== sv/wav_header_parser_top.sv =====
// Top level of the WAV header parser: byte input, one result beat per file.
// The result is registered in the output buffer before it shows on out_valid.
// Throughput: one byte per cycle; input stalls only while the skid entry holds a result.
// Byte count per file: 36 header bytes, plus 2 and the extra count when fmt size exceeds 24,
// plus 8 data-chunk bytes, counted by the parser state machine's byte and skip counters.
// Reset (synchronous, rst high) returns the parser to the header phase and empties the buffer.
module wav_header_parser_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  whp_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output whp_pkg::out_beat_t out_data
);

  logic                  accept;
  logic                  full;
  whp_pkg::result_push_t result;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  // Parser state machine.
  whp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .beat   (in_data),
    .result (result)
  );

  // Output register and skid entry.
  whp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A result is only produced by an accepted byte.
  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    result.push |-> accept)
    else $error("result pushed without an accepted byte");

  // The skid entry is only occupied behind a valid output register.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid entry full while output register empty");

  // Error results carry zero fields.
  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (result.push && result.beat.status != whp_pkg::StatusOk) |->
      (result.beat.channels == 16'd0 && result.beat.sample_rate == 32'd0 &&
       result.beat.bits_per_sample == 16'd0 && !result.beat.big_endian &&
       !result.beat.signed_samples))
    else $error("error result with nonzero fields");

  // Nothing is presented in the first cycle after reset is released.
  a_empty_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !out_valid && !in_stall)
    else $error("buffer not empty after reset");

endmodule
